[design/ptc_pkg.sv]
`default_nettype none

package ptc_pkg;

   localparam int RAW_W     = 24;
   localparam int CAL_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int OUT_W     = 32;
   localparam int DT_W      = 25;
   localparam int T_W       = 18;
   localparam int T2_W      = 17;
   localparam int OFF_W     = 36;
   localparam int SENS_W    = 35;
   localparam int TF_W      = 19;
   localparam int TEMP_BASE = 2000;

   typedef enum logic [1:0] {
      KIND_FIRST  = 2'd0,
      KIND_SECOND = 2'd1,
      KIND_THIRD  = 2'd2,
      KIND_DEPTH  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENSOR_KIND       = 3'd0,
      CSR_CAL_SENS          = 3'd1,
      CSR_CAL_OFFSET        = 3'd2,
      CSR_CAL_SENS_TEMPCO   = 3'd3,
      CSR_CAL_OFFSET_TEMPCO = 3'd4,
      CSR_CAL_REF_TEMP      = 3'd5,
      CSR_CAL_TEMP_COEF     = 3'd6
   } csr_index_type;

   typedef struct packed {
      kind_type           kind;
      logic [CAL_W-1:0]   sens;
      logic [CAL_W-1:0]   offset;
      logic [CAL_W-1:0]   sens_tempco;
      logic [CAL_W-1:0]   offset_tempco;
      logic [CAL_W-1:0]   ref_temp;
      logic [CAL_W-1:0]   temp_coef;
   } cfg_type;

   typedef struct packed {
      logic signed [T_W-1:0]    t;
      logic [T2_W-1:0]          t2;
      logic signed [OFF_W-1:0]  off;
      logic signed [SENS_W-1:0] sens;
      logic [RAW_W-1:0]         d1;
   } mid_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] pressure_out;
      logic signed [OUT_W-1:0] temperature_out;
      logic                    cold_correction;
   } rsp_type;

   // signed divide by 2^k, rounding toward zero
   function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                    input int unsigned k);
      logic signed [63:0] bias;
      bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
      return (x + bias) >>> k;
   endfunction

endpackage

`default_nettype wire

[design/ptc_chan_if.sv]
`default_nettype none

interface ptc_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptc_pkg::RAW_W-1:0]     pressure_code;
   logic [ptc_pkg::RAW_W-1:0]     temperature_code;

   modport source (output valid, output pressure_code, output temperature_code, input ready);
   modport sink   (input valid, input pressure_code, input temperature_code, output ready);
endinterface

interface ptc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [ptc_pkg::OUT_W-1:0] pressure_out;
   logic signed [ptc_pkg::OUT_W-1:0] temperature_out;
   logic                             cold_correction;

   modport source (output valid, output pressure_out, output temperature_out,
                   output cold_correction, input ready);
   modport sink   (input valid, input pressure_out, input temperature_out,
                   input cold_correction, output ready);
endinterface

`default_nettype wire

[design/ptc_csr.sv]
`default_nettype none

module ptc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ptc_pkg::CAL_W-1:0]       csr_wdata,
   output ptc_pkg::cfg_type                cfg
);

   ptc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind          <= ptc_pkg::KIND_DEPTH;
         cfg_ff.sens          <= '0;
         cfg_ff.offset        <= '0;
         cfg_ff.sens_tempco   <= '0;
         cfg_ff.offset_tempco <= '0;
         cfg_ff.ref_temp      <= '0;
         cfg_ff.temp_coef     <= '0;
      end else if (csr_write_en) begin
         unique case (ptc_pkg::csr_index_type'(csr_index))
            ptc_pkg::CSR_SENSOR_KIND:       cfg_ff.kind <= ptc_pkg::kind_type'(csr_wdata[1:0]);
            ptc_pkg::CSR_CAL_SENS:          cfg_ff.sens <= csr_wdata;
            ptc_pkg::CSR_CAL_OFFSET:        cfg_ff.offset <= csr_wdata;
            ptc_pkg::CSR_CAL_SENS_TEMPCO:   cfg_ff.sens_tempco <= csr_wdata;
            ptc_pkg::CSR_CAL_OFFSET_TEMPCO: cfg_ff.offset_tempco <= csr_wdata;
            ptc_pkg::CSR_CAL_REF_TEMP:      cfg_ff.ref_temp <= csr_wdata;
            ptc_pkg::CSR_CAL_TEMP_COEF:     cfg_ff.temp_coef <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/ptc_front.sv]
`default_nettype none

module ptc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [ptc_pkg::RAW_W-1:0]    pressure_code,
   input  logic [ptc_pkg::RAW_W-1:0]    temperature_code,
   input  ptc_pkg::cfg_type             cfg,
   output logic                         mid_valid,
   output ptc_pkg::mid_type             mid
);

   localparam int PROD_W = ptc_pkg::DT_W + ptc_pkg::CAL_W + 1;
   localparam int SQ_W   = 2 * ptc_pkg::DT_W;
   localparam int DD_W   = 2 * ptc_pkg::DT_W - 2;

   logic v1_ff, v2_ff, v3_ff;

   logic signed [ptc_pkg::DT_W-1:0] dt1_in, dt1_ff;
   logic [ptc_pkg::RAW_W-1:0]       d1_1_ff, d1_2_ff;

   logic signed [PROD_W-1:0] pt2_in, pt2_ff;
   logic signed [PROD_W-1:0] po2_in, po2_ff;
   logic signed [PROD_W-1:0] ps2_in, ps2_ff;
   logic signed [SQ_W-1:0]   sq2;
   logic [DD_W-1:0]          pd2_in, pd2_ff;

   logic                     wide;
   logic signed [63:0]       t_full, off_full, sens_full;
   logic [SQ_W-1:0]          dd3;
   ptc_pkg::mid_type         mid_in, mid_ff;

   // stage 1: offset from reference temperature
   assign dt1_in = $signed({1'b0, temperature_code}) - $signed({1'b0, cfg.ref_temp, 8'h00});

   // stage 2: products of dT
   assign pt2_in = dt1_ff * $signed({1'b0, cfg.temp_coef});
   assign po2_in = dt1_ff * $signed({1'b0, cfg.offset_tempco});
   assign ps2_in = dt1_ff * $signed({1'b0, cfg.sens_tempco});
   assign sq2    = dt1_ff * dt1_ff;
   assign pd2_in = sq2[DD_W-1:0];

   // stage 3: first-order terms
   always_comb begin
      wide      = (cfg.kind == ptc_pkg::KIND_SECOND) || (cfg.kind == ptc_pkg::KIND_THIRD);
      t_full    = ptc_pkg::trunc_shr(64'(pt2_ff), 23);
      if (wide) begin
         off_full  = ($signed(64'(cfg.offset)) <<< 17) + ptc_pkg::trunc_shr(64'(po2_ff), 6);
         sens_full = ($signed(64'(cfg.sens)) <<< 16) + ptc_pkg::trunc_shr(64'(ps2_ff), 7);
      end else begin
         off_full  = ($signed(64'(cfg.offset)) <<< 16) + ptc_pkg::trunc_shr(64'(po2_ff), 7);
         sens_full = ($signed(64'(cfg.sens)) <<< 15) + ptc_pkg::trunc_shr(64'(ps2_ff), 8);
      end
      dd3       = SQ_W'(pd2_ff) + (SQ_W'(pd2_ff) << 1);
      mid_in.t    = t_full[ptc_pkg::T_W-1:0];
      mid_in.off  = off_full[ptc_pkg::OFF_W-1:0];
      mid_in.sens = sens_full[ptc_pkg::SENS_W-1:0];
      mid_in.d1   = d1_2_ff;
      if (cfg.kind == ptc_pkg::KIND_FIRST || cfg.kind == ptc_pkg::KIND_SECOND) begin
         mid_in.t2 = pd2_ff[31 +: ptc_pkg::T2_W];
      end else begin
         mid_in.t2 = dd3[33 +: ptc_pkg::T2_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dt1_ff  <= dt1_in;
         d1_1_ff <= pressure_code;
         pt2_ff  <= pt2_in;
         po2_ff  <= po2_in;
         ps2_ff  <= ps2_in;
         pd2_ff  <= pd2_in;
         d1_2_ff <= d1_1_ff;
         mid_ff  <= mid_in;
      end
   end

   assign mid_valid = v3_ff;
   assign mid       = mid_ff;

endmodule

`default_nettype wire

[design/ptc_back.sv]
`default_nettype none

module ptc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  mid_valid,
   input  ptc_pkg::mid_type      mid,
   input  ptc_pkg::kind_type     kind,
   output logic                  out_valid,
   output ptc_pkg::rsp_type      out_data
);

   localparam int A_W     = 2 * ptc_pkg::T_W - 2;
   localparam int AX_W    = A_W + 6;
   localparam int OFFF_W  = ptc_pkg::OFF_W + 2;
   localparam int SENSF_W = ptc_pkg::SENS_W + 2;
   localparam int SL_W    = 19;
   localparam int PP_W    = ptc_pkg::RAW_W + SL_W;
   localparam int PROD_W  = ptc_pkg::RAW_W + SENSF_W + 1;
   localparam int Q_W     = 41;

   logic v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;

   // stage 4: square of t, first temperature correction
   logic signed [2*ptc_pkg::T_W-1:0]  sq4;
   logic [A_W-1:0]                    a4_in, a4_ff;
   logic                              cold4_in, cold4_ff;
   logic signed [ptc_pkg::TF_W-1:0]   tf4_in, tf4_ff;
   logic signed [ptc_pkg::OFF_W-1:0]  off4_ff;
   logic signed [ptc_pkg::SENS_W-1:0] sens4_ff;
   logic [ptc_pkg::RAW_W-1:0]         d1_4_ff;

   assign sq4      = mid.t * mid.t;
   assign a4_in    = sq4[A_W-1:0];
   assign cold4_in = mid.t[ptc_pkg::T_W-1];
   assign tf4_in   = {mid.t[ptc_pkg::T_W-1], mid.t}
                   - (cold4_in ? {2'b00, mid.t2} : {ptc_pkg::TF_W{1'b0}});

   // stage 5: second-order offset and sensitivity
   logic [AX_W-1:0]                 ax, a3x, a5x, a29x, a61x, off2_w, sens2_w;
   logic [ptc_pkg::OFF_W-1:0]       off2;
   logic [ptc_pkg::SENS_W-1:0]      sens2;
   logic signed [OFFF_W-1:0]        off5_in, off5_ff;
   logic signed [SENSF_W-1:0]       sens5_in, sens5_ff;
   logic signed [ptc_pkg::TF_W-1:0] tf5_ff;
   logic                            cold5_ff;
   logic [ptc_pkg::RAW_W-1:0]       d1_5_ff;

   always_comb begin
      ax   = AX_W'(a4_ff);
      a3x  = (ax << 1) + ax;
      a5x  = (ax << 2) + ax;
      a29x = (ax << 5) - (ax << 1) - ax;
      a61x = (ax << 6) - (ax << 1) - ax;
      unique case (kind)
         ptc_pkg::KIND_FIRST: begin
            off2_w  = a5x >> 1;
            sens2_w = a5x >> 2;
         end
         ptc_pkg::KIND_SECOND: begin
            off2_w  = a61x >> 4;
            sens2_w = ax << 1;
         end
         ptc_pkg::KIND_THIRD: begin
            off2_w  = a61x >> 4;
            sens2_w = a29x >> 4;
         end
         ptc_pkg::KIND_DEPTH: begin
            off2_w  = a3x >> 1;
            sens2_w = a5x >> 3;
         end
      endcase
      off2     = cold4_ff ? off2_w[ptc_pkg::OFF_W-1:0] : '0;
      sens2    = cold4_ff ? sens2_w[ptc_pkg::SENS_W-1:0] : '0;
      off5_in  = {{2{off4_ff[ptc_pkg::OFF_W-1]}}, off4_ff} - {2'b00, off2};
      sens5_in = {{2{sens4_ff[ptc_pkg::SENS_W-1]}}, sens4_ff} - {2'b00, sens2};
   end

   // stage 6: split product D1 * SENS
   logic [PP_W-1:0]                 pl6_in, pl6_ff;
   logic signed [PP_W-1:0]          ph6_in, ph6_ff;
   logic signed [OFFF_W-1:0]        off6_ff;
   logic signed [ptc_pkg::TF_W-1:0] tf6_ff;
   logic                            cold6_ff;

   assign pl6_in = d1_5_ff * sens5_ff[SL_W-1:0];
   assign ph6_in = $signed({1'b0, d1_5_ff}) * $signed(sens5_ff[SENSF_W-1:SL_W]);

   // stage 7: join partial products
   logic signed [PROD_W-1:0]        prod7_in, prod7_ff;
   logic signed [OFFF_W-1:0]        off7_ff;
   logic signed [ptc_pkg::TF_W-1:0] tf7_ff;
   logic                            cold7_ff;

   assign prod7_in = ($signed(PROD_W'(ph6_ff)) <<< SL_W) + $signed({{(PROD_W-PP_W){1'b0}}, pl6_ff});

   // stage 8: remove offset
   logic signed [63:0]              q_full;
   logic signed [Q_W-1:0]           q8_in, q8_ff;
   logic signed [ptc_pkg::TF_W-1:0] tf8_ff;
   logic                            cold8_ff;

   assign q_full = ptc_pkg::trunc_shr(64'(prod7_ff), 21) - 64'(off7_ff);
   assign q8_in  = q_full[Q_W-1:0];

   // stage 9: scale to output units
   logic signed [63:0]  p_full, p10;
   ptc_pkg::rsp_type    out9_in, out9_ff;

   always_comb begin
      if (kind == ptc_pkg::KIND_DEPTH) begin
         p_full = ptc_pkg::trunc_shr(64'(q8_ff), 13);
         p10    = (p_full <<< 3) + (p_full <<< 1);
      end else begin
         p_full = ptc_pkg::trunc_shr(64'(q8_ff), 15);
         p10    = p_full;
      end
      out9_in.pressure_out    = p10[ptc_pkg::OUT_W-1:0];
      out9_in.temperature_out = ptc_pkg::OUT_W'(tf8_ff)
                              + ptc_pkg::OUT_W'(ptc_pkg::TEMP_BASE);
      out9_in.cold_correction = cold8_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= mid_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a4_ff    <= a4_in;
         cold4_ff <= cold4_in;
         tf4_ff   <= tf4_in;
         off4_ff  <= mid.off;
         sens4_ff <= mid.sens;
         d1_4_ff  <= mid.d1;

         off5_ff  <= off5_in;
         sens5_ff <= sens5_in;
         tf5_ff   <= tf4_ff;
         cold5_ff <= cold4_ff;
         d1_5_ff  <= d1_4_ff;

         pl6_ff   <= pl6_in;
         ph6_ff   <= ph6_in;
         off6_ff  <= off5_ff;
         tf6_ff   <= tf5_ff;
         cold6_ff <= cold5_ff;

         prod7_ff <= prod7_in;
         off7_ff  <= off6_ff;
         tf7_ff   <= tf6_ff;
         cold7_ff <= cold6_ff;

         q8_ff    <= q8_in;
         tf8_ff   <= tf7_ff;
         cold8_ff <= cold7_ff;

         out9_ff  <= out9_in;
      end
   end

   assign out_valid = v9_ff;
   assign out_data  = out9_ff;

   a_cold_follows_sign: assert property (@(posedge clock) disable iff (reset)
      (en && mid_valid && mid.t[ptc_pkg::T_W-1]) |=> cold4_ff)
      else $error("cold flag lost for negative temperature term");

   a_cold_temp_negative: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && cold4_ff) |-> tf4_ff[ptc_pkg::TF_W-1])
      else $error("corrected temperature term not negative");

endmodule

`default_nettype wire

[design/ptc_skid.sv]
`default_nettype none

module ptc_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ptc_pkg::rsp_type   in_data,
   output logic               in_ready,
   output logic               out_valid,
   output ptc_pkg::rsp_type   out_data,
   input  logic               out_ready
);

   logic             main_valid_ff, skid_valid_ff;
   ptc_pkg::rsp_type main_data_ff, skid_data_ff;
   logic             main_free;

   assign main_free = out_ready || !main_valid_ff;
   assign in_ready  = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= in_valid;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_valid && !skid_valid_ff) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid beat held without a beat in front");

   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_ready) |=> (skid_valid_ff && $stable(skid_data_ff)))
      else $error("skid beat dropped or overwritten while stalled");

endmodule

`default_nettype wire

[design/pressure_temperature_compensation.sv]
// Compensated pressure and temperature from one raw conversion pair.
//
// req_chan carries one beat per sample: pressure_code and temperature_code,
// accepted when valid and ready are both high. rsp_chan returns exactly one
// beat per request, in order: pressure_out (0.01 mbar), temperature_out
// (0.01 C) and cold_correction, set when the low temperature terms applied.
// The user must write calibration words and sensor_kind over the csr_ port
// while no request is in flight; the block does not enforce this, and an
// index above six is ignored.
//
// The pipeline has three stages for dT and the first-order terms, six for
// the second-order correction, the split D1 x SENS product and its sum,
// offset removal and scaling, and one output stage.
// A new request can be taken every cycle while the skid slot is empty.
// The output stage has a skid slot, so req_chan.ready is a register and does
// not follow rsp_chan.ready in the same cycle; when the receiver stalls, the
// whole pipeline holds with nothing dropped or repeated.
// Reset clears all beats in flight and sets sensor_kind to the depth kind
// and every calibration word to zero.
`default_nettype none

module pressure_temperature_compensation (
   input  logic                           clock,
   input  logic                           reset,
   ptc_req_if.sink                        req_chan,
   ptc_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_en,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptc_pkg::CAL_W-1:0]      csr_wdata
);

   ptc_pkg::cfg_type  cfg;
   ptc_pkg::mid_type  mid;
   ptc_pkg::rsp_type  pipe_data, rsp_data;
   logic              en, mid_valid, pipe_valid;

   ptc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   ptc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (req_chan.valid),
      .pressure_code    (req_chan.pressure_code),
      .temperature_code (req_chan.temperature_code),
      .cfg              (cfg),
      .mid_valid        (mid_valid),
      .mid              (mid)
   );

   ptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .mid_valid (mid_valid),
      .mid       (mid),
      .kind      (cfg.kind),
      .out_valid (pipe_valid),
      .out_data  (pipe_data)
   );

   ptc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pipe_valid),
      .in_data   (pipe_data),
      .in_ready  (en),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_data),
      .out_ready (rsp_chan.ready)
   );

   assign req_chan.ready           = en;
   assign rsp_chan.pressure_out    = rsp_data.pressure_out;
   assign rsp_chan.temperature_out = rsp_data.temperature_out;
   assign rsp_chan.cold_correction = rsp_data.cold_correction;

endmodule

`default_nettype wire
